### rtl/core/pfdc_pkg.sv
// Shared types, constants and helpers for the Playfair digram cipher unit.
package pfdc_pkg;

  localparam int unsigned SQ_DIM    = 5;
  localparam int unsigned SQ_CELLS  = SQ_DIM * SQ_DIM;
  localparam int unsigned LW        = 5;
  localparam int unsigned SQ_W      = SQ_CELLS * LW;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned IDX_W     = 5;

  localparam logic [LW-1:0] CODE_I = 5'd8;
  localparam logic [LW-1:0] CODE_J = 5'd9;
  localparam logic [LW-1:0] CODE_Z = 5'd25;

  localparam logic [POS_W-1:0] POS_LAST = 3'(SQ_DIM - 1);

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Register indexes (byte address bits [4:3])
  localparam logic [1:0] REG_ROWS_0_1 = 2'd0;
  localparam logic [1:0] REG_ROWS_2_3 = 2'd1;
  localparam logic [1:0] REG_ROW_4    = 2'd2;

  localparam int unsigned ROWS2_W = 2 * SQ_DIM * LW;
  localparam int unsigned ROW1_W  = SQ_DIM * LW;

  typedef struct packed {
    logic          command;
    logic [LW-1:0] letter_first;
    logic [LW-1:0] letter_second;
  } in_t;

  typedef struct packed {
    logic [LW-1:0] out_first;
    logic [LW-1:0] out_second;
    logic          bad_pair;
  } out_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_t;

  // Entry at (row, col) of the flattened square, entry 0 in the low bits.
  function automatic logic [LW-1:0] cell_at(input logic [SQ_W-1:0] sq,
                                            input logic [POS_W-1:0] row,
                                            input logic [POS_W-1:0] col);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(row) * IDX_W'(SQ_DIM) + IDX_W'(col);
    return sq[idx * LW +: LW];
  endfunction

  // Neighbor position with wrap: +1 for encrypt, -1 for decrypt.
  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                input logic cmd);
    logic [POS_W-1:0] q;
    if (cmd == CMD_DECRYPT) begin
      q = (p == '0) ? POS_LAST : p - POS_W'(1);
    end else begin
      q = (p == POS_LAST) ? '0 : p + POS_W'(1);
    end
    return q;
  endfunction

endpackage

### rtl/core/pfdc_locate.sv
// Parallel search of one letter across the 25 square entries.
module pfdc_locate
  import pfdc_pkg::*;
(
  input  logic [LW-1:0]   letter,
  input  logic [SQ_W-1:0] square,
  output loc_t            loc
);

  always_comb begin
    loc = '0;
    // later entries override earlier ones: highest matching index wins
    for (int r = 0; r < SQ_DIM; r++) begin
      for (int c = 0; c < SQ_DIM; c++) begin
        if (square[(r * SQ_DIM + c) * LW +: LW] == letter) begin
          loc.found = 1'b1;
          loc.row   = POS_W'(r);
          loc.col   = POS_W'(c);
        end
      end
    end
    if (letter > CODE_Z) begin
      loc.found = 1'b0;
    end
  end

endmodule

### rtl/core/pfdc_xform.sv
// Playfair rule logic: locate both letters and pick the substituted entries.
module pfdc_xform
  import pfdc_pkg::*;
(
  input  in_t             item,
  input  logic [SQ_W-1:0] square,
  output out_t            result
);

  logic [LW-1:0] let_a;
  logic [LW-1:0] let_b;
  loc_t          loc_a;
  loc_t          loc_b;

  assign let_a = (item.letter_first  == CODE_J) ? CODE_I : item.letter_first;
  assign let_b = (item.letter_second == CODE_J) ? CODE_I : item.letter_second;

  pfdc_locate u_loc_a (.letter(let_a), .square(square), .loc(loc_a));
  pfdc_locate u_loc_b (.letter(let_b), .square(square), .loc(loc_b));

  always_comb begin
    result = '0;
    if ((let_a == let_b) || !loc_a.found || !loc_b.found) begin
      result.bad_pair = 1'b1;
    end else if (loc_a.row == loc_b.row) begin
      result.out_first  = cell_at(square, loc_a.row, step_pos(loc_a.col, item.command));
      result.out_second = cell_at(square, loc_b.row, step_pos(loc_b.col, item.command));
    end else if (loc_a.col == loc_b.col) begin
      result.out_first  = cell_at(square, step_pos(loc_a.row, item.command), loc_a.col);
      result.out_second = cell_at(square, step_pos(loc_b.row, item.command), loc_b.col);
    end else begin
      result.out_first  = cell_at(square, loc_a.row, loc_b.col);
      result.out_second = cell_at(square, loc_b.row, loc_a.col);
    end
  end

endmodule

### rtl/core/playfair_digram_cipher_unit.sv
// Top level of the Playfair digram cipher unit: key square registers and pipeline.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+-----------------------------
//  input    | start & !busy                     | in_item   (in_t)
//  result   | out_valid, one-cycle strobe       | out_result (out_t)
//  config   | psel & penable & pwrite (APB)     | paddr/pwdata, 64-bit data bus
//
// One transaction per cycle while busy is low; an accepted item goes to the input
// register, then its result goes to the result register after the search, and the
// result strobe rises as the result register is loaded.
// busy is high during reset, is cleared by the first clock edge with rst_n high and stays low otherwise.
// Synchronous active-low reset clears the valid bits and the key square.
// The receiver cannot stall; results are never held.
module playfair_digram_cipher_unit
  import pfdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_item,
  output logic        out_valid,
  output out_t        out_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [ROWS2_W-1:0] rows01_r;
  logic [ROWS2_W-1:0] rows23_r;
  logic [ROW1_W-1:0]  row4_r;
  logic [SQ_W-1:0]    square;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  logic               busy_r;
  logic               stg_vld_r;
  in_t                stg_item_r;
  logic               res_vld_r;
  out_t               res_r;
  out_t               res_nxt;
  logic               accept;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign square  = {row4_r, rows23_r, rows01_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows01_r <= '0;
      rows23_r <= '0;
      row4_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROWS_0_1: rows01_r <= pwdata[ROWS2_W-1:0];
        REG_ROWS_2_3: rows23_r <= pwdata[ROWS2_W-1:0];
        REG_ROW_4:    row4_r   <= pwdata[ROW1_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_0_1: prdata = 64'(rows01_r);
      REG_ROWS_2_3: prdata = 64'(rows23_r);
      REG_ROW_4:    prdata = 64'(row4_r);
      default:      prdata = '0;
    endcase
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      stg_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      stg_vld_r <= accept;
      res_vld_r <= stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_item_r <= in_item;
    end
    if (stg_vld_r) begin
      res_r <= res_nxt;
    end
  end

  pfdc_xform u_xform (
    .item   (stg_item_r),
    .square (square),
    .result (res_nxt)
  );

  assign out_valid  = res_vld_r;
  assign out_result = res_r;

endmodule

### rtl/core/pfdc_checker.sv
// Port-level checks for the Playfair digram cipher unit, bound to the top level.
module pfdc_checker
  import pfdc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_item,
  input logic out_valid,
  input out_t out_result
);

  // every accepted transaction yields a result once it has passed the input and result registers
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  // no result without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted transaction");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.bad_pair) |->
      (out_result.out_first == '0 && out_result.out_second == '0))
    else $error("error result carries nonzero letters");

  // identical or out-of-range letters must flag an error
  a_bad_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_item.letter_first == in_item.letter_second, 2) ||
                   $past(in_item.letter_first > CODE_Z, 2) ||
                   $past(in_item.letter_second > CODE_Z, 2)))
      |-> out_result.bad_pair)
    else $error("invalid digram not flagged");

endmodule

bind playfair_digram_cipher_unit pfdc_checker u_pfdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_valid  (out_valid),
  .out_result (out_result)
);

### tb/tb_playfair_digram_cipher_unit.sv
// Self-checking testbench for the Playfair digram cipher unit.
module tb_playfair_digram_cipher_unit;
  import pfdc_pkg::*;

  localparam int DIM = SQ_DIM;
  localparam int CELLS = SQ_CELLS;
  localparam int KEYS_RANDOM = 6;
  localparam int DIGRAMS_PER_KEY = 100;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // Key square as the predictor sees it, entry 0 in the low bits
  logic [SQ_W-1:0] key_square;
  out_t            pending_digrams[$];
  int              mismatches;
  int              digrams_sent;
  int              results_seen;
  int              bad_pairs_seen;
  int              reg_writes;
  int              burst_left;

  playfair_digram_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [LW-1:0] square_entry(input int e);
    return key_square[e*LW +: LW];
  endfunction

  function automatic out_t playfair_predict(input in_t d);
    logic [LW-1:0] a;
    logic [LW-1:0] b;
    int            ea;
    int            eb;
    int            e;
    int            ra;
    int            ca;
    int            rb;
    int            cb;
    int            shift;
    out_t          r;
    r = '0;
    a = (d.letter_first == CODE_J) ? CODE_I : d.letter_first;
    b = (d.letter_second == CODE_J) ? CODE_I : d.letter_second;
    ea = -1;
    eb = -1;
    // last match wins when the square holds a letter twice
    for (e = 0; e < CELLS; e++) begin
      if (a <= CODE_Z && square_entry(e) == a) ea = e;
      if (b <= CODE_Z && square_entry(e) == b) eb = e;
    end
    if (a == b || ea < 0 || eb < 0) begin
      r.bad_pair = 1'b1;
      return r;
    end
    shift = (d.command == CMD_DECRYPT) ? DIM - 1 : 1;
    ra = ea / DIM;
    ca = ea % DIM;
    rb = eb / DIM;
    cb = eb % DIM;
    if (ra == rb) begin
      r.out_first  = square_entry(ra * DIM + (ca + shift) % DIM);
      r.out_second = square_entry(rb * DIM + (cb + shift) % DIM);
    end else if (ca == cb) begin
      r.out_first  = square_entry(((ra + shift) % DIM) * DIM + ca);
      r.out_second = square_entry(((rb + shift) % DIM) * DIM + cb);
    end else begin
      r.out_first  = square_entry(ra * DIM + cb);
      r.out_second = square_entry(rb * DIM + ca);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_result.bad_pair) bad_pairs_seen++;
      if (pending_digrams.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d/%0d bad=%0b", out_result.out_first,
                                out_result.out_second, out_result.bad_pair));
      end else begin
        want = pending_digrams.pop_front();
        if (want.out_first !== out_result.out_first ||
            want.out_second !== out_result.out_second ||
            want.bad_pair !== out_result.bad_pair) begin
          flag_mismatch($sformatf("exp %0d/%0d bad=%0b got %0d/%0d bad=%0b",
                                  want.out_first, want.out_second, want.bad_pair,
                                  out_result.out_first, out_result.out_second,
                                  out_result.bad_pair));
        end
      end
    end
  end

  // Drives one digram, holds it until the accepting edge; leaves start high.
  task automatic send_digram(input logic cmd, input logic [LW-1:0] a,
                             input logic [LW-1:0] b);
    in_t d;
    d.command = cmd;
    d.letter_first = a;
    d.letter_second = b;
    start <= 1'b1;
    in_item <= d;
    do @(posedge clk); while (busy);
    pending_digrams = {pending_digrams, playfair_predict(d)};
    digrams_sent++;
    @(negedge clk);
  endtask

  // Bursts of back-to-back transactions separated by random gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_digrams.size() != 0 && guard < 200) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] kept;
    kept = (idx == REG_ROW_4) ? value & ((64'd1 << ROW1_W) - 64'd1)
                              : value & ((64'd1 << ROWS2_W) - 64'd1);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROWS_0_1: key_square[0 +: ROWS2_W] = kept[ROWS2_W-1:0];
      REG_ROWS_2_3: key_square[ROWS2_W +: ROWS2_W] = kept[ROWS2_W-1:0];
      default:      key_square[2*ROWS2_W +: ROW1_W] = kept[ROW1_W-1:0];
    endcase
    reg_writes++;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) begin
      flag_mismatch($sformatf("reg %0d readback exp %h got %h", idx, kept, prdata));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_square(input logic [SQ_W-1:0] sq);
    drain();
    write_reg(REG_ROWS_0_1, 64'(sq[0 +: ROWS2_W]));
    write_reg(REG_ROWS_2_3, 64'(sq[ROWS2_W +: ROWS2_W]));
    write_reg(REG_ROW_4, 64'(sq[2*ROWS2_W +: ROW1_W]));
  endtask

  // a..z without j, row-major
  function automatic logic [SQ_W-1:0] alphabet_square();
    logic [SQ_W-1:0] sq;
    int              e;
    for (e = 0; e < CELLS; e++) sq[e*LW +: LW] = LW'((e < int'(CODE_J)) ? e : e + 1);
    return sq;
  endfunction

  function automatic logic [SQ_W-1:0] shuffled_square();
    logic [SQ_W-1:0] sq;
    logic [LW-1:0]   held;
    int              e;
    int              k;
    sq = alphabet_square();
    for (e = CELLS - 1; e > 0; e--) begin
      k = $urandom_range(0, e);
      held = sq[e*LW +: LW];
      sq[e*LW +: LW] = sq[k*LW +: LW];
      sq[k*LW +: LW] = held;
    end
    return sq;
  endfunction

  // Random 5-bit entries up to max_code: duplicates, and codes above z if max_code > 25
  function automatic logic [SQ_W-1:0] scrambled_square(input int max_code);
    logic [SQ_W-1:0] sq;
    int              e;
    for (e = 0; e < CELLS; e++) sq[e*LW +: LW] = LW'($urandom_range(0, max_code));
    return sq;
  endfunction

  task automatic send_random_digram();
    int            pick;
    logic [LW-1:0] a;
    logic [LW-1:0] b;
    pick = $urandom_range(0, 99);
    a = square_entry($urandom_range(0, CELLS - 1));
    b = square_entry($urandom_range(0, CELLS - 1));
    if (pick >= 80 && pick < 88) begin
      a = LW'($urandom_range(0, 31));
      b = LW'($urandom_range(0, 31));
    end else if (pick >= 88 && pick < 94) begin
      a = CODE_J;
    end else if (pick >= 94) begin
      b = CODE_J;
    end
    send_digram(1'($urandom_range(0, 1)), a, b);
    pace_sender();
  endtask

  // Square is all zero out of reset: everything must flag bad_pair
  task automatic test_reset_square();
    send_digram(CMD_ENCRYPT, 5'd0, 5'd0);
    send_digram(CMD_ENCRYPT, 5'd0, 5'd1);
    send_digram(CMD_DECRYPT, 5'd25, 5'd0);
    send_digram(CMD_DECRYPT, 5'd31, 5'd0);
    pace_sender();
  endtask

  task automatic test_directed_rules();
    load_square(alphabet_square());
    send_digram(CMD_ENCRYPT, 5'd0, 5'd1);    // same row
    send_digram(CMD_ENCRYPT, 5'd3, 5'd4);    // row wrap right
    send_digram(CMD_DECRYPT, 5'd0, 5'd2);    // row wrap left
    send_digram(CMD_DECRYPT, 5'd4, 5'd3);
    send_digram(CMD_ENCRYPT, 5'd25, 5'd24);  // last row, wrap
    send_digram(CMD_ENCRYPT, 5'd0, 5'd21);   // same column, wrap down
    send_digram(CMD_DECRYPT, 5'd0, 5'd5);    // same column, wrap up
    send_digram(CMD_DECRYPT, 5'd25, 5'd4);
    send_digram(CMD_ENCRYPT, 5'd7, 5'd17);   // rectangle
    send_digram(CMD_DECRYPT, 5'd7, 5'd17);
    send_digram(CMD_ENCRYPT, CODE_J, 5'd0);  // j taken as i
    send_digram(CMD_DECRYPT, 5'd1, CODE_J);
    send_digram(CMD_ENCRYPT, CODE_J, CODE_I); // identical after j->i
    send_digram(CMD_DECRYPT, CODE_J, CODE_J);
    send_digram(CMD_ENCRYPT, 5'd12, 5'd12);  // identical letters
    send_digram(CMD_ENCRYPT, 5'd26, 5'd0);   // codes above z
    send_digram(CMD_DECRYPT, 5'd0, 5'd31);
    send_digram(CMD_ENCRYPT, 5'd31, 5'd31);
    send_digram(CMD_DECRYPT, 5'd30, 5'd21);
    send_digram(CMD_ENCRYPT, 5'd25, 5'd0);
    pace_sender();
  endtask

  task automatic test_odd_squares();
    logic [SQ_W-1:0] sq;
    int              n;
    // all-ones registers: every entry is 31, never matched
    load_square({SQ_W{1'b1}});
    send_digram(CMD_ENCRYPT, 5'd31, 5'd0);
    send_digram(CMD_DECRYPT, 5'd25, 5'd31);
    // j stored in place of i: neither j nor i can be found
    sq = alphabet_square();
    sq[8*LW +: LW] = CODE_J;
    load_square(sq);
    send_digram(CMD_ENCRYPT, CODE_J, 5'd0);
    send_digram(CMD_ENCRYPT, CODE_I, 5'd1);
    send_digram(CMD_DECRYPT, 5'd10, 5'd0);
    // heavy duplicates: highest index wins
    load_square(scrambled_square(3));
    for (n = 0; n < 30; n++) send_random_digram();
    // entries above z come out verbatim
    load_square(scrambled_square(31));
    for (n = 0; n < 30; n++) send_random_digram();
  endtask

  task automatic test_random_keys();
    int k;
    int n;
    for (k = 0; k < KEYS_RANDOM; k++) begin
      load_square((k == 2) ? scrambled_square(31) : shuffled_square());
      for (n = 0; n < DIGRAMS_PER_KEY; n++) send_random_digram();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_square = '0;
    mismatches = 0;
    digrams_sent = 0;
    results_seen = 0;
    bad_pairs_seen = 0;
    reg_writes = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_square();
    test_directed_rules();
    test_odd_squares();
    test_random_keys();
    drain();

    $display("Sent %0d digrams over %0d register writes; %0d results checked, %0d bad pairs.",
             digrams_sent, reg_writes, results_seen, bad_pairs_seen);
    $display("%0d mismatches, %0d results never arrived.", mismatches,
             pending_digrams.size());
    if (mismatches == 0 && pending_digrams.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: run did not complete");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/pfdc_pkg.sv
rtl/core/pfdc_locate.sv
rtl/core/pfdc_xform.sv
rtl/core/playfair_digram_cipher_unit.sv
rtl/core/pfdc_checker.sv
tb/tb_playfair_digram_cipher_unit.sv
